### rtl/assert_macros.svh
// Assertion helpers for the alignment marker block.
// Each check is sampled on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

### rtl/pcsami_pkg.sv
`timescale 1ns / 1ps
package pcsami_pkg;

    localparam int LANE_COUNT = 4;
    localparam int LANE_W     = 2;
    localparam int HDR_W      = 2;
    localparam int PAY_W      = 64;
    localparam int CNT_W      = 16;

    localparam logic [CNT_W-1:0]  INTERVAL_RESET = 16'd16383;
    localparam logic [HDR_W-1:0]  HDR_CONTROL    = 2'b01;
    localparam logic [LANE_W-1:0] LAST_LANE      = LANE_W'(LANE_COUNT - 1);

    // Fixed marker bytes per lane, byte i in bits 8i+7..8i; BIP3/BIP7 slots zero.
    function automatic logic [PAY_W-1:0] marker_base(input logic [LANE_W-1:0] lane);
        logic [PAY_W-1:0] m;
        begin
            case (lane)
                2'd0:    m = 64'h00B8_896F_0047_7690;
                2'd1:    m = 64'h0019_3B0F_00E6_C4F0;
                2'd2:    m = 64'h0064_9A3A_009B_65C5;
                2'd3:    m = 64'h00C2_865D_003D_79A2;
                default: m = '0;
            endcase
            return m;
        end
    endfunction

    // Interleaved parity: payload bit p to parity bit p mod 8,
    // header bit 0 to parity bit 3, header bit 1 to parity bit 4.
    function automatic logic [7:0] block_parity(input logic [HDR_W-1:0] hdr,
                                                input logic [PAY_W-1:0] pay);
        logic [7:0] p;
        begin
            p = '0;
            for (int i = 0; i < PAY_W / 8; i++)
            begin
                p = p ^ pay[8*i +: 8];
            end
            p[3] = p[3] ^ hdr[0];
            p[4] = p[4] ^ hdr[1];
            return p;
        end
    endfunction

endpackage

### rtl/pcsami_ifs.sv
`timescale 1ns / 1ps
interface pcsami_in_if
    import pcsami_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [LANE_W-1:0] lane_index;
    logic [HDR_W-1:0]  in_header;
    logic [PAY_W-1:0]  in_payload;

    modport source (output valid, lane_index, in_header, in_payload, input ready);
    modport sink   (input valid, lane_index, in_header, in_payload, output ready);
endinterface

interface pcsami_out_if
    import pcsami_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [HDR_W-1:0] out_header;
    logic [PAY_W-1:0] out_payload;
    logic             marker_inserted;

    modport source (output valid, out_header, out_payload, marker_inserted, input ready);
    modport sink   (input valid, out_header, out_payload, marker_inserted, output ready);
endinterface

### rtl/pcsami_marker_mux.sv
`timescale 1ns / 1ps
module pcsami_marker_mux
    import pcsami_pkg::*;
(
    input  logic [LANE_W-1:0] lane,
    input  logic [HDR_W-1:0]  hdr,
    input  logic [PAY_W-1:0]  pay,
    input  logic [7:0]        bip3,
    input  logic              need,
    output logic [HDR_W-1:0]  sel_hdr,
    output logic [PAY_W-1:0]  sel_pay,
    output logic [7:0]        sel_parity
);

    logic [PAY_W-1:0] marker;

    always_comb
    begin
        marker          = marker_base(lane);
        marker[31:24]   = bip3;
        marker[63:56]   = ~bip3;
        sel_hdr         = need ? HDR_CONTROL : hdr;
        sel_pay         = need ? marker : pay;
        sel_parity      = block_parity(sel_hdr, sel_pay);
    end

endmodule

### rtl/pcs_alignment_marker_insert.sv
`timescale 1ns / 1ps
// 40GBASE-R alignment marker insertion with per-lane BIP. Each 66-bit word
// on lane_blk is registered in stage one, then either passed through
// or replaced by its lane's alignment marker (BIP3 in byte 3, BIP7 in byte 7)
// and registered on tx_blk; marker_inserted = 1 means the input word was
// dropped and must be sent again. One word is accepted every cycle unless
// tx_blk stalls; the only loop is the lane parity and round counter
// update, which closes in the single compute stage. The user must write
// marker_interval only while the block is idle; the block itself does not enforce it.
module pcs_alignment_marker_insert
    import pcsami_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              marker_interval_we,
    input  logic [CNT_W-1:0]  marker_interval_wdata,
    pcsami_in_if.sink         lane_blk,
    pcsami_out_if.source      tx_blk
);

`include "assert_macros.svh"

    logic [CNT_W-1:0]  marker_interval_reg;
    logic [CNT_W-1:0]  round_count_reg;
    logic [CNT_W-1:0]  round_count_next;
    logic [7:0]        lane_parity_reg [LANE_COUNT];

    logic              s1_valid_reg;
    logic [LANE_W-1:0] s1_lane_reg;
    logic [HDR_W-1:0]  s1_hdr_reg;
    logic [PAY_W-1:0]  s1_pay_reg;

    logic              out_valid_reg;
    logic [HDR_W-1:0]  out_hdr_reg;
    logic [PAY_W-1:0]  out_pay_reg;
    logic              out_mark_reg;

    logic              advance;
    logic              lane_ok;
    logic              need;
    logic [7:0]        bip3;
    logic [HDR_W-1:0]  sel_hdr;
    logic [PAY_W-1:0]  sel_pay;
    logic [7:0]        sel_parity;

    assign advance = s1_valid_reg && (!out_valid_reg || tx_blk.ready);
    assign lane_ok = ({1'b0, s1_lane_reg} < (LANE_W + 1)'(LANE_COUNT));
    assign need    = lane_ok && (round_count_reg >= marker_interval_reg);
    assign bip3    = lane_ok ? lane_parity_reg[s1_lane_reg] : 8'h00;

    assign lane_blk.ready = !s1_valid_reg || advance;

    assign tx_blk.valid           = out_valid_reg;
    assign tx_blk.out_header      = out_hdr_reg;
    assign tx_blk.out_payload     = out_pay_reg;
    assign tx_blk.marker_inserted = out_mark_reg;

    pcsami_marker_mux u_mux (
        .lane       (s1_lane_reg),
        .hdr        (s1_hdr_reg),
        .pay        (s1_pay_reg),
        .bip3       (bip3),
        .need       (need),
        .sel_hdr    (sel_hdr),
        .sel_pay    (sel_pay),
        .sel_parity (sel_parity)
    );

    // Clear on the last lane of a marker round, advance on the last lane otherwise.
    always_comb
    begin
        round_count_next = round_count_reg;
        if (lane_ok && (s1_lane_reg == LAST_LANE))
        begin
            if (need)
            begin
                round_count_next = '0;
            end
            else
            begin
                round_count_next = round_count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_interval_reg <= INTERVAL_RESET;
            round_count_reg     <= '0;
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            for (int i = 0; i < LANE_COUNT; i++)
            begin
                lane_parity_reg[i] <= '0;
            end
        end
        else
        begin
            if (marker_interval_we)
            begin
                marker_interval_reg <= marker_interval_wdata;
            end
            if (lane_blk.ready)
            begin
                s1_valid_reg <= lane_blk.valid;
            end
            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                round_count_reg <= round_count_next;
                if (lane_ok)
                begin
                    // Restart the lane parity after a marker, then fold in this word.
                    lane_parity_reg[s1_lane_reg] <= need ? sel_parity : (bip3 ^ sel_parity);
                end
            end
            else if (tx_blk.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (lane_blk.valid && lane_blk.ready)
        begin
            s1_lane_reg <= lane_blk.lane_index;
            s1_hdr_reg  <= lane_blk.in_header;
            s1_pay_reg  <= lane_blk.in_payload;
        end
        if (advance)
        begin
            out_hdr_reg  <= sel_hdr;
            out_pay_reg  <= sel_pay;
            out_mark_reg <= need;
        end
    end

    `ASSERT_CLK(a_marker_bip7, (out_valid_reg && out_mark_reg) |-> ((out_hdr_reg == HDR_CONTROL) && (out_pay_reg[63:56] == ~out_pay_reg[31:24])), "marker BIP7 is not the complement of BIP3")
    `ASSERT_CLK(a_round_clear, (advance && need && (s1_lane_reg == LAST_LANE)) |=> (round_count_reg == '0), "round count not cleared after marker round")
    `ASSERT_NEVER(a_no_overrun, s1_valid_reg && !advance && lane_blk.ready, "input taken while stage one is stalled")

endmodule
